// File: src/led_matrix_row_serializer_core_assert.svh
// assertion macros for the led matrix row serializer
`ifndef LED_MATRIX_ROW_SERIALIZER_CORE_ASSERT_SVH
`define LED_MATRIX_ROW_SERIALIZER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LMRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lmrs assertion failed");

// next-cycle implication, checked outside reset
`define LMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lmrs assertion failed");

`endif

// File: src/lmrs_pkg.sv
// shared types and constants for the led matrix row serializer
package lmrs_pkg;

    localparam int MATRIX_SIZE_DEF  = 8;
    localparam int DOT_CHANNELS_DEF = 18;

    localparam int PIX_BITS = 24;
    localparam int DC_W     = 6;

    localparam logic [DC_W-1:0] DC_RESET = 6'd63;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DOT   = 1'b1;

    // bank select levels
    localparam logic BANK_DOT  = 1'b0;
    localparam logic BANK_GRAY = 1'b1;

    // clock pulses per result
    localparam logic [3:0] GRAY_BITS  = 4'd8;
    localparam logic [3:0] DOT_BITS   = 4'd6;
    localparam logic [3:0] LATCH_BITS = 4'd0;

    // index of the final bit of a byte
    localparam logic [2:0] GRAY_LAST_BIT = 3'd7;
    localparam logic [2:0] DOT_LAST_BIT  = 3'd5;

    typedef struct packed {
        logic load_pixel;
        logic load_dot;
        logic step;
        logic clear;
        logic dot_mode;
    } t_ser_ctl;

endpackage

// File: src/lmrs_serdes.sv
// row shift register, dot correction rotator and bit-serial byte assembler
module lmrs_serdes
    import lmrs_pkg::*;
#(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
    input  logic            i_clk,
    input  t_ser_ctl        i_ctl,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic [DC_W-1:0] i_dot_correction,
    output logic [7:0]      o_byte
);

    localparam int BUF_W = PIX_BITS * MATRIX_SIZE;

    logic [BUF_W-1:0] r_buf;
    logic [DC_W-1:0]  r_dc;
    logic [7:0]       r_acc;
    logic             w_bit;

    assign w_bit  = i_ctl.dot_mode ? r_dc[DC_W-1] : r_buf[BUF_W-1];
    assign o_byte = {r_acc[6:0], w_bit};

    // newest pixel enters at the top so the last pixel of a row goes out first
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pixel) begin
            r_buf <= {i_blue, i_green, i_red, r_buf[BUF_W-1:PIX_BITS]};
        end else if (i_ctl.step && !i_ctl.dot_mode) begin
            r_buf <= {r_buf[BUF_W-2:0], 1'b0};
        end
    end

    // rotation brings the value back after each six-bit byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_dot) begin
            r_dc <= i_dot_correction;
        end else if (i_ctl.step && i_ctl.dot_mode) begin
            r_dc <= {r_dc[DC_W-2:0], r_dc[DC_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pixel || i_ctl.load_dot) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= i_ctl.clear ? 8'd0 : o_byte;
        end
    end

endmodule

// File: src/led_matrix_row_serializer_core.sv
// Row-scanning serializer for an RGB LED matrix behind a two-bank serial
// constant-current driver. Pixel beats fill a MATRIX_SIZE-entry row. The
// pixel that completes the row is accepted and then starts a flush: the row
// shift register puts out one bit per cycle, except while the final bit of
// a byte waits for room in the output register, so the 3*MATRIX_SIZE
// grayscale bytes go out (blue, green, red of the last pixel first),
// followed by a latch that enables the next row. A dot correction load is
// accepted, shifts out DOT_CHANNELS six-bit bytes and ends with a latch. A
// finished byte waits in a single output register, so an output stall only
// costs cycles when the previous beat is still waiting at the moment the
// next byte (or the latch) is complete. The input is ready only between
// items; the configuration port is always ready, and the user must see that
// it is written only while idle: the block itself does not enforce it.
`include "led_matrix_row_serializer_core_assert.svh"

module led_matrix_row_serializer_core
    import lmrs_pkg::*;
#(
    parameter int MATRIX_SIZE  = MATRIX_SIZE_DEF,
    parameter int DOT_CHANNELS = DOT_CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_kind,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_bank_select,
    output logic [7:0]      o_shift_data,
    output logic [3:0]      o_bit_count,
    output logic            o_latch_pulse,
    output logic [7:0]      o_row_enable,
    output logic            o_last,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [DC_W-1:0] i_cfg_dot_correction
);

    localparam int PIX_W      = $clog2(MATRIX_SIZE);
    localparam int GRAY_BYTES = 3 * MATRIX_SIZE;
    localparam int MAX_BYTES  = (GRAY_BYTES > DOT_CHANNELS) ? GRAY_BYTES : DOT_CHANNELS;
    localparam int CNT_W      = $clog2(MAX_BYTES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GRAY  = 4'b0010,
        S_DOT   = 4'b0100,
        S_LATCH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [PIX_W-1:0] r_pix_cnt, n_pix_cnt;
    logic [PIX_W-1:0] r_row_cnt, n_row_cnt;
    logic [7:0]       r_active_rows, n_active_rows;
    logic [DC_W-1:0]  r_dot_corr;
    logic             r_bank, n_bank;
    logic [2:0]       r_bit_cnt, n_bit_cnt;
    logic [CNT_W-1:0] r_byte_cnt, n_byte_cnt;

    logic             r_out_valid, n_out_valid;
    logic             r_out_bank, n_out_bank;
    logic [7:0]       r_out_data, n_out_data;
    logic [3:0]       r_out_bits, n_out_bits;
    logic             r_out_latch, n_out_latch;
    logic [7:0]       r_out_rows, n_out_rows;
    logic             r_out_last, n_out_last;

    t_ser_ctl         w_ctl;
    logic [7:0]       w_byte;
    logic             w_in_accept;
    logic             w_slot_free;
    logic             w_gray;
    logic             w_at_last;
    logic             w_byte_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_gray      = (r_state == S_GRAY);
    assign w_at_last   = (r_bit_cnt == (w_gray ? GRAY_LAST_BIT : DOT_LAST_BIT));
    assign w_byte_last = w_gray ? (r_byte_cnt == CNT_W'(GRAY_BYTES - 1))
                                : (r_byte_cnt == CNT_W'(DOT_CHANNELS - 1));

    lmrs_serdes #(
        .MATRIX_SIZE(MATRIX_SIZE)
    ) u_serdes (
        .i_clk            (i_clk),
        .i_ctl            (w_ctl),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_dot_correction (r_dot_corr),
        .o_byte           (w_byte)
    );

    always_comb begin
        n_state       = r_state;
        n_pix_cnt     = r_pix_cnt;
        n_row_cnt     = r_row_cnt;
        n_active_rows = r_active_rows;
        n_bank        = r_bank;
        n_bit_cnt     = r_bit_cnt;
        n_byte_cnt    = r_byte_cnt;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_bank    = r_out_bank;
        n_out_data    = r_out_data;
        n_out_bits    = r_out_bits;
        n_out_latch   = r_out_latch;
        n_out_rows    = r_out_rows;
        n_out_last    = r_out_last;
        w_ctl          = '0;
        w_ctl.dot_mode = (r_state == S_DOT);

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_bit_cnt  = '0;
                    n_byte_cnt = '0;
                    if (i_kind == KIND_DOT) begin
                        w_ctl.load_dot = 1'b1;
                        n_bank         = BANK_DOT;
                        n_state        = S_DOT;
                    end else begin
                        w_ctl.load_pixel = 1'b1;
                        if (r_pix_cnt == PIX_W'(MATRIX_SIZE - 1)) begin
                            n_pix_cnt = '0;
                            n_bank    = BANK_GRAY;
                            n_state   = S_GRAY;
                        end else begin
                            n_pix_cnt = r_pix_cnt + 1'b1;
                        end
                    end
                end
            end
            S_GRAY, S_DOT: begin
                // the final bit of a byte waits for room in the output register
                if (!w_at_last || w_slot_free) begin
                    w_ctl.step  = 1'b1;
                    w_ctl.clear = w_at_last;
                    n_bit_cnt   = w_at_last ? 3'd0 : r_bit_cnt + 1'b1;
                end
                if (w_at_last && w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_bank  = r_bank;
                    n_out_data  = w_byte;
                    n_out_bits  = w_gray ? GRAY_BITS : DOT_BITS;
                    n_out_latch = 1'b0;
                    n_out_rows  = r_active_rows;
                    n_out_last  = 1'b0;
                    n_byte_cnt  = r_byte_cnt + 1'b1;
                    if (w_byte_last) begin
                        n_state = S_LATCH;
                    end
                end
            end
            S_LATCH: begin
                if (w_slot_free) begin
                    if (r_bank == BANK_GRAY) begin
                        n_active_rows = 8'd1 << r_row_cnt;
                        n_row_cnt     = (r_row_cnt == PIX_W'(MATRIX_SIZE - 1)) ? '0
                                                                             : r_row_cnt + 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_out_bank  = r_bank;
                    n_out_data  = 8'd0;
                    n_out_bits  = LATCH_BITS;
                    n_out_latch = 1'b1;
                    n_out_rows  = n_active_rows;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pix_cnt     <= '0;
            r_row_cnt     <= '0;
            r_active_rows <= '0;
            r_dot_corr    <= DC_RESET;
            r_bank        <= BANK_DOT;
            r_bit_cnt     <= '0;
            r_byte_cnt    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pix_cnt     <= n_pix_cnt;
            r_row_cnt     <= n_row_cnt;
            r_active_rows <= n_active_rows;
            r_bank        <= n_bank;
            r_bit_cnt     <= n_bit_cnt;
            r_byte_cnt    <= n_byte_cnt;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dot_corr <= i_cfg_dot_correction;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bank  <= n_out_bank;
        r_out_data  <= n_out_data;
        r_out_bits  <= n_out_bits;
        r_out_latch <= n_out_latch;
        r_out_rows  <= n_out_rows;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_bank_select = r_out_bank;
    assign o_shift_data  = r_out_data;
    assign o_bit_count   = r_out_bits;
    assign o_latch_pulse = r_out_latch;
    assign o_row_enable  = r_out_rows;
    assign o_last        = r_out_last;

    // rows shown on a pending beat always match the live row state
    `LMRS_ASSERT_IMPL(a_rows_track, i_clk, i_rst_n, o_out_valid, o_row_enable == r_active_rows)
    // shift beats are never last and carry a full grayscale or dot byte
    `LMRS_ASSERT_IMPL(a_shift_beat, i_clk, i_rst_n, o_out_valid && !o_latch_pulse, !o_last && (o_bit_count == GRAY_BITS || o_bit_count == DOT_BITS))
    // a row flush only runs once the pixel count has wrapped
    `LMRS_ASSERT_IMPL(a_flush_count, i_clk, i_rst_n, r_state == S_GRAY, r_pix_cnt == '0)
    // the latch ends the item and leaves a last beat behind
    `LMRS_ASSERT_NEXT(a_latch_ends, i_clk, i_rst_n, r_state == S_LATCH && w_slot_free, r_state == S_IDLE && o_out_valid && o_latch_pulse && o_last)

endmodule
